// ----- rtl/core/deq_pkg.sv -----
// deq_pkg: request and result types and request codes for the deque.
// No dependencies; used by double_ended_queue.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [1:0] REQ_POP_BACK   = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [VALUE_W-1:0] push_value;
  } deq_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] pop_value;
    logic               was_empty;
    logic               was_full;
    logic [COUNT_W-1:0] entry_count;
  } deq_rsp_t;

endpackage

// ----- rtl/core/deq_ram.sv -----
// deq_ram: generic RAM, one write port and one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/double_ended_queue.sv -----
// double_ended_queue: bounded deque in a ring RAM with front index and count.
// Depends on deq_pkg and deq_ram.
// Push, or pop on an empty queue: result strobed in the cycle after acceptance, busy stays low,
// so one such request per cycle. Pop on a non-empty queue: busy is high in ST_READ while the
// RAM's registered read completes, and the result is strobed from ST_READ.
// Synchronous reset clears front index, count and control; RAM contents are not cleared.
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  deq_pkg::deq_req_t req,
  output logic              done,
  output deq_pkg::deq_rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  typedef enum logic {ST_IDLE, ST_READ} state_t;

  state_t          state;
  logic [AW-1:0]   front;
  logic [CW-1:0]   count;

  logic            accept;
  logic            is_push;
  logic            full;
  logic            empty;
  logic [AW-1:0]   front_prev;
  logic [AW-1:0]   front_next;
  logic [SW-1:0]   back_push_sum;
  logic [SW-1:0]   back_pop_sum;
  logic [AW-1:0]   back_push;
  logic [AW-1:0]   back_pop;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign is_push = (req.req_type == deq_pkg::REQ_PUSH_FRONT) ||
                   (req.req_type == deq_pkg::REQ_PUSH_BACK);
  assign full    = (count == DEPTH_C);
  assign empty   = (count == '0);

  assign front_prev = (front == '0) ? LAST_IDX : front - AW'(1);
  assign front_next = (front == LAST_IDX) ? '0 : front + AW'(1);

  // front + count and front + count - 1, wrapped once modulo DEPTH
  assign back_push_sum = SW'(front) + SW'(count);
  assign back_pop_sum  = SW'(front) + SW'(count) - SW'(1);
  assign back_push = (back_push_sum >= DEPTH_S) ? AW'(back_push_sum - DEPTH_S)
                                                 : AW'(back_push_sum);
  assign back_pop  = (back_pop_sum >= DEPTH_S) ? AW'(back_pop_sum - DEPTH_S)
                                                : AW'(back_pop_sum);

  assign wr_en   = accept && is_push && !full;
  assign wr_addr = (req.req_type == deq_pkg::REQ_PUSH_FRONT) ? front_prev : back_push;
  assign rd_en   = accept && !is_push && !empty;
  assign rd_addr = (req.req_type == deq_pkg::REQ_POP_FRONT) ? front : back_pop;

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (DATA_WIDTH'(req.push_value)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      front <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_push) begin
              done                <= 1'b1;
              rsp.pop_value       <= '0;
              rsp.was_empty       <= 1'b0;
              rsp.was_full        <= full;
              rsp.entry_count     <= full ? deq_pkg::COUNT_W'(count)
                                          : deq_pkg::COUNT_W'(count + CW'(1));
              if (!full) begin
                count <= count + CW'(1);
                if (req.req_type == deq_pkg::REQ_PUSH_FRONT) begin
                  front <= front_prev;
                end
              end
            end else if (empty) begin
              done            <= 1'b1;
              rsp.pop_value   <= '0;
              rsp.was_empty   <= 1'b1;
              rsp.was_full    <= 1'b0;
              rsp.entry_count <= deq_pkg::COUNT_W'(count);
            end else begin
              state <= ST_READ;
              count <= count - CW'(1);
              if (req.req_type == deq_pkg::REQ_POP_FRONT) begin
                front <= front_next;
              end
            end
          end
        end
        ST_READ: begin
          done            <= 1'b1;
          rsp.pop_value   <= deq_pkg::VALUE_W'(rd_data);
          rsp.was_empty   <= 1'b0;
          rsp.was_full    <= 1'b0;
          rsp.entry_count <= deq_pkg::COUNT_W'(count);
          state           <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking testbench for double_ended_queue, driving requests
// through start/busy and checking every strobed result. Depends on deq_pkg.
`timescale 1ns / 1ps

module tb_top;
  import deq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int IDX_W        = 4;
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 700;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  deq_req_t req = '0;
  logic     busy;
  logic     done;
  deq_rsp_t rsp;

  double_ended_queue #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(VALUE_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp)
  );

  // deque state kept alongside the block
  logic [VALUE_W-1:0] ring_copy [DEPTH];
  logic [IDX_W-1:0]   head_idx = '0;
  logic [COUNT_W-1:0] held = '0;

  deq_rsp_t pending_results[$];
  bit       steady_traffic = 1'b0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_empty_pops = 0;
  int       n_full_pushes = 0;
  int       n_errors = 0;
  int       cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic deq_rsp_t predict_deque(deq_req_t r);
    deq_rsp_t res;
    res = '0;
    case (r.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (held == COUNT_W'(DEPTH)) begin
          res.was_full = 1'b1;
          n_full_pushes++;
        end else if (r.req_type == REQ_PUSH_FRONT) begin
          head_idx = head_idx - 1'b1;
          ring_copy[head_idx] = r.push_value;
          held = held + 1'b1;
        end else begin
          ring_copy[head_idx + IDX_W'(held)] = r.push_value;
          held = held + 1'b1;
        end
      end
      default: begin
        if (held == '0) begin
          res.was_empty = 1'b1;
          n_empty_pops++;
        end else if (r.req_type == REQ_POP_FRONT) begin
          res.pop_value = ring_copy[head_idx];
          head_idx = head_idx + 1'b1;
          held = held - 1'b1;
        end else begin
          res.pop_value = ring_copy[head_idx + IDX_W'(held - 1'b1)];
          held = held - 1'b1;
        end
      end
    endcase
    res.entry_count = held;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_traffic) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t tb_top: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(input deq_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_deque(r));
    n_sent++;
  endtask

  task automatic send_kind(input logic [1:0] kind, input logic [VALUE_W-1:0] value);
    deq_req_t r;
    r.req_type   = kind;
    r.push_value = value;
    send_request(r);
  endtask

  task automatic wait_until_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic test_empty_pops();
    send_kind(REQ_POP_FRONT, 32'hFFFF_FFFF);
    send_kind(REQ_POP_BACK, 32'h0000_0000);
  endtask

  task automatic test_fill_to_full();
    send_kind(REQ_PUSH_FRONT, 32'h0000_0000);
    send_kind(REQ_PUSH_BACK, 32'hFFFF_FFFF);
    send_kind(REQ_PUSH_FRONT, 32'hAAAA_AAAA);
    send_kind(REQ_PUSH_BACK, 32'h5555_5555);
    for (int i = 0; i < DEPTH - 4; i++) begin
      send_kind((i % 2 == 0) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, $urandom);
    end
  endtask

  task automatic test_full_drops();
    send_kind(REQ_PUSH_FRONT, 32'h1234_5678);
    send_kind(REQ_PUSH_BACK, 32'h8765_4321);
    send_kind(REQ_POP_FRONT, 32'h0);
    send_kind(REQ_POP_BACK, 32'h0);
  endtask

  // bursts with a varying push/pop bias so the queue swings between empty and full
  task automatic test_random_traffic(input int count);
    int             sent;
    int             burst_len;
    int             push_pct;
    int             pick;
    logic [1:0]     kind;
    logic [VALUE_W-1:0] value;
    sent = 0;
    while (sent < count) begin
      burst_len = $urandom_range(20, 60);
      pick = $urandom_range(0, 4);
      push_pct = (pick == 0) ? 10 : (pick == 1) ? 90 : (pick == 2) ? 25 :
                 (pick == 3) ? 75 : 50;
      steady_traffic = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < burst_len && sent < count; i++) begin
        if ($urandom_range(0, 99) < push_pct)
          kind = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        else
          kind = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
        pick = $urandom_range(0, 15);
        value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
        send_kind(kind, value);
        sent++;
      end
    end
    steady_traffic = 1'b0;
  endtask

  always @(posedge clk) begin
    deq_rsp_t want;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_top: timeout after %0d cycles", cycles);
      $display("tb_top: FAIL");
      $finish;
    end
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t tb_top: result with no request waiting, actual %0h", $time, rsp);
      end else begin
        want = pending_results.pop_front();
        compare_field("pop_value", want.pop_value, rsp.pop_value);
        compare_field("was_empty", 32'(want.was_empty), 32'(rsp.was_empty));
        compare_field("was_full", 32'(want.was_full), 32'(rsp.was_full));
        compare_field("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
        n_checked++;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_pops();
    test_fill_to_full();
    test_full_drops();
    test_random_traffic(RANDOM_ITEMS / 2);
    wait_until_idle();
    test_random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2);
    wait_until_idle();

    if (pending_results.size() != 0) begin
      n_errors++;
      $display("%0t tb_top: %0d results never arrived", $time, pending_results.size());
    end
    $display("tb_top: %0d requests sent, %0d results checked, %0d errors",
             n_sent, n_checked, n_errors);
    $display("tb_top: %0d pops on an empty queue, %0d pushes dropped on a full queue",
             n_empty_pops, n_full_pushes);
    if (n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
